// ----- hdl/cell_monitor_frame_parser_assert.svh -----
// Assertion macros shared by the checker of the cell monitor frame parser.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef CELL_MONITOR_FRAME_PARSER_ASSERT_SVH
`define CELL_MONITOR_FRAME_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define CMFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmfp assertion failed");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define CMFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmfp assertion failed");

// Consequent must hold in the cycle after the antecedent, reset included.
`define CMFP_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cmfp assertion failed");

`endif

// ----- hdl/cmfp_pkg.sv -----
// Types and constants of the cell monitor frame parser.
// No dependencies; used by the top level and its checker.
package cmfp_pkg;

  localparam int ID_W      = 29;
  localparam int VOLT_W    = 16;
  localparam int TEMP_W    = 8;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 16;
  localparam int OVER_W    = 3;
  localparam int CELLS_W   = 5;
  localparam int POS_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 29;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OV_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT = 2'd3;

  // register reset values
  localparam logic [ID_W-1:0]    BASE_ID_RST    = '0;
  localparam logic [VOLT_W-1:0]  OV_LIMIT_RST   = 16'hFFFF;
  localparam logic [CELLS_W-1:0] CELLS_RST      = 5'd19;
  localparam logic [VOLT_W-1:0]  RX_TIMEOUT_RST = 16'd1000;

  // identifier offset windows
  localparam logic [ID_W-1:0] OFS_VOLT_LO = 29'd1;
  localparam logic [ID_W-1:0] OFS_VOLT_HI = 29'd5;
  localparam logic [ID_W-1:0] OFS_TEMP_LO = 29'd21;
  localparam logic [ID_W-1:0] OFS_TEMP_HI = 29'd25;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   frame_id;
    logic [63:0]       payload;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic                     accepted;
    logic [OVER_W-1:0]        over_count;
    logic [VOLT_W-1:0]        max_voltage;
    logic [VOLT_W-1:0]        min_voltage;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [TEMP_W-1:0] min_temp;
    logic                     voltage_link_error;
  } out_t;

endpackage

// ----- hdl/cell_monitor_frame_parser.sv -----
// Top level of the cell monitor frame parser.
// Depends on cmfp_pkg and two instances of cmfp_ram.
//
// Usage
//   Input channel in_valid/in_ready/in_data carries one item: a frame
//   (func = 0) or a time poll (func = 1), each with a millisecond time.
//   Output channel out_valid/out_ready/out_data returns exactly one result
//   per item, in order. Configuration is a write port (cfg_we, cfg_addr,
//   cfg_data); write only while the block is idle.
//   Voltages and over-voltage counters share one RAM, temperatures sit in a
//   second; a valid bit per entry makes entries unwritten since reset read 0.
// Sequence
//   Poll or rejected frame: the result is loaded without any RAM access.
//   Voltage frame: each cell is read and written back in turn, then a scan
//   of all VOLT_CELLS entries; the writes stop early when the frame runs
//   past the last cell. Temperature frame: each sensor slot is written,
//   then the scan of all TEMP_SENSORS entries over the RAM's single read port.
//   One item is worked on at a time; in_ready is high only while idle,
//   which the block enters again as the result is loaded.
// Reset and stalls
//   Reset clears stored values and extremes, restores register defaults and
//   sets the deadline to the default timeout. While out_ready is low the
//   result holds in the output register; the next item may still be taken,
//   but its finished result waits in the sequencer until the register frees.
module cell_monitor_frame_parser #(
  parameter int VOLT_CELLS   = 19,
  parameter int TEMP_SENSORS = 38
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cmfp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [cmfp_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cmfp_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cmfp_pkg::out_t                      out_data
);

  localparam int VAW      = $clog2(VOLT_CELLS);
  localparam int TAW      = $clog2(TEMP_SENSORS);
  localparam int SCAN_MAX = (VOLT_CELLS > TEMP_SENSORS) ? VOLT_CELLS : TEMP_SENSORS;
  localparam int SCW      = $clog2(SCAN_MAX + 1);
  localparam int VRAM_W   = cmfp_pkg::VOLT_W + cmfp_pkg::CNT_W;
  localparam logic [SCW-1:0] VLIM = SCW'(VOLT_CELLS);
  localparam logic [SCW-1:0] TLIM = SCW'(TEMP_SENSORS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VRD,
    S_VWR,
    S_TWR,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [cmfp_pkg::ID_W-1:0]    base_id;
  logic [cmfp_pkg::VOLT_W-1:0]  ov_limit;
  logic [cmfp_pkg::CELLS_W-1:0] cells_in_use;
  logic [cmfp_pkg::VOLT_W-1:0]  rx_timeout;

  // item context
  logic [63:0]                  payload;
  logic [cmfp_pkg::POS_W-1:0]   pos;
  logic [2:0]                   lane;
  logic                         is_volt;
  logic                         accepted;
  logic [cmfp_pkg::OVER_W-1:0]  over_cnt;
  logic                         link_err;
  logic [cmfp_pkg::TIME_W-1:0]  deadline;

  // stored extremes
  logic [cmfp_pkg::VOLT_W-1:0]         vmax;
  logic [cmfp_pkg::VOLT_W-1:0]         vmin;
  logic signed [cmfp_pkg::TEMP_W-1:0]  tmax;
  logic signed [cmfp_pkg::TEMP_W-1:0]  tmin;

  // scan control
  logic [SCW-1:0] sidx;
  logic           scan_pv;
  logic           scan_first;
  logic           scan_issue;

  // valid bits and RAM ports
  logic [VOLT_CELLS-1:0]    vvalid;
  logic [TEMP_SENSORS-1:0]  tvalid;
  logic                     vq_ok;
  logic                     tq_ok;
  logic [VAW-1:0]           vr_addr;
  logic [VAW-1:0]           vw_addr;
  logic                     vw_en;
  logic [VRAM_W-1:0]        vw_data;
  logic [VRAM_W-1:0]        vram_q;
  logic [VRAM_W-1:0]        vq;
  logic [TAW-1:0]           tr_addr;
  logic [TAW-1:0]           tw_addr;
  logic                     tw_en;
  logic [cmfp_pkg::TEMP_W-1:0] tram_q;
  logic [cmfp_pkg::TEMP_W-1:0] tq;

  // per-lane values
  logic [cmfp_pkg::VOLT_W-1:0] v_new;
  logic [cmfp_pkg::TEMP_W-1:0] t_new;
  logic                        over_hit;
  logic [cmfp_pkg::CNT_W-1:0]  cnt_old;
  logic [cmfp_pkg::CNT_W-1:0]  cnt_new;
  logic                        v_in_range;
  logic                        t_in_range;

  // accept-time decode
  logic                        in_fire;
  logic [cmfp_pkg::ID_W:0]     diff;
  logic [cmfp_pkg::ID_W-1:0]   ofs;
  logic                        id_above;
  logic                        volt_frame;
  logic                        temp_frame;
  logic [2:0]                  v_blk;
  logic [4:0]                  t_ofs;
  logic [cmfp_pkg::TIME_W-1:0] deadline_next;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // offset taken as a difference; a borrow means the identifier is below base
  assign diff     = {1'b0, in_data.frame_id} - {1'b0, base_id};
  assign ofs      = diff[cmfp_pkg::ID_W-1:0];
  assign id_above = !diff[cmfp_pkg::ID_W];
  assign volt_frame = (in_data.func == cmfp_pkg::FUNC_FRAME) && id_above &&
                      (ofs >= cmfp_pkg::OFS_VOLT_LO) && (ofs <= cmfp_pkg::OFS_VOLT_HI);
  assign temp_frame = (in_data.func == cmfp_pkg::FUNC_FRAME) && id_above &&
                      (ofs >= cmfp_pkg::OFS_TEMP_LO) && (ofs <= cmfp_pkg::OFS_TEMP_HI);
  assign v_blk = ofs[2:0] - 3'd1;
  assign t_ofs = ofs[4:0] - cmfp_pkg::OFS_TEMP_LO[4:0];
  assign deadline_next = volt_frame ?
                         (in_data.now_ms + {16'd0, rx_timeout}) : deadline;

  // lane extraction: byte 0 sits in the top bits
  assign v_new = payload[{~lane[1:0], 4'b0000} +: cmfp_pkg::VOLT_W];
  assign t_new = payload[{~lane, 3'b000} +: cmfp_pkg::TEMP_W];

  assign v_in_range = 32'(pos) < VOLT_CELLS;
  assign t_in_range = 32'(pos) < TEMP_SENSORS;

  // entries never written read as zero
  assign vq = vq_ok ? vram_q : '0;
  assign tq = tq_ok ? tram_q : '0;

  assign over_hit = (v_new > ov_limit) && (pos[cmfp_pkg::CELLS_W-1:0] < cells_in_use);
  assign cnt_old  = vq[cmfp_pkg::CNT_W-1:0];
  assign cnt_new  = (over_hit && (cnt_old != cmfp_pkg::CNT_MAX)) ? cnt_old + 1'b1 : cnt_old;

  assign scan_issue = (state == S_SCAN) && (sidx < (is_volt ? VLIM : TLIM));

  always_comb begin
    vr_addr = (state == S_SCAN) ? sidx[VAW-1:0] : pos[VAW-1:0];
    vw_addr = pos[VAW-1:0];
    vw_en   = (state == S_VWR);
    vw_data = {v_new, cnt_new};
    tr_addr = sidx[TAW-1:0];
    tw_addr = pos[TAW-1:0];
    tw_en   = (state == S_TWR) && t_in_range;
  end

  cmfp_ram #(
    .WIDTH (VRAM_W),
    .DEPTH (VOLT_CELLS)
  ) u_volt_ram (
    .clk   (clk),
    .we    (vw_en),
    .waddr (vw_addr),
    .wdata (vw_data),
    .raddr (vr_addr),
    .rdata (vram_q)
  );

  cmfp_ram #(
    .WIDTH (cmfp_pkg::TEMP_W),
    .DEPTH (TEMP_SENSORS)
  ) u_temp_ram (
    .clk   (clk),
    .we    (tw_en),
    .waddr (tw_addr),
    .wdata (t_new),
    .raddr (tr_addr),
    .rdata (tram_q)
  );

  always_ff @(posedge clk) begin
    // valid bit follows the read address with the RAM's latency
    vq_ok      <= vvalid[vr_addr];
    tq_ok      <= tvalid[tr_addr];
    scan_pv    <= scan_issue;
    scan_first <= (sidx == '0);

    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      base_id      <= cmfp_pkg::BASE_ID_RST;
      ov_limit     <= cmfp_pkg::OV_LIMIT_RST;
      cells_in_use <= cmfp_pkg::CELLS_RST;
      rx_timeout   <= cmfp_pkg::RX_TIMEOUT_RST;
      deadline     <= {16'd0, cmfp_pkg::RX_TIMEOUT_RST};
      vvalid       <= '0;
      tvalid       <= '0;
      vmax         <= '0;
      vmin         <= '0;
      tmax         <= '0;
      tmin         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cmfp_pkg::REG_BASE_ID:    base_id      <= cfg_data;
          cmfp_pkg::REG_OV_LIMIT:   ov_limit     <= cfg_data[cmfp_pkg::VOLT_W-1:0];
          cmfp_pkg::REG_CELLS:      cells_in_use <= cfg_data[cmfp_pkg::CELLS_W-1:0];
          cmfp_pkg::REG_RX_TIMEOUT: rx_timeout   <= cfg_data[cmfp_pkg::VOLT_W-1:0];
          default: ;
        endcase
      end

      // free the output register once the result is taken, unless a
      // finished result reloads it in the same cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            payload  <= in_data.payload;
            deadline <= deadline_next;
            link_err <= in_data.now_ms > deadline_next;
            accepted <= volt_frame || temp_frame;
            is_volt  <= volt_frame;
            over_cnt <= '0;
            lane     <= '0;
            sidx     <= '0;
            if (volt_frame) begin
              pos   <= {1'b0, v_blk, 2'b00};
              state <= S_VRD;
            end else if (temp_frame) begin
              pos   <= {t_ofs[2:0], 3'b000};
              state <= S_TWR;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_VRD: begin
          // read issued this cycle; past the last cell drop to the scan
          state <= v_in_range ? S_VWR : S_SCAN;
        end

        S_VWR: begin
          // write back voltage and bumped counter
          vvalid[vw_addr] <= 1'b1;
          if (over_hit) begin
            over_cnt <= over_cnt + 1'b1;
          end
          pos  <= pos + 1'b1;
          lane <= lane + 1'b1;
          state <= (lane[1:0] == 2'd3) ? S_SCAN : S_VRD;
        end

        S_TWR: begin
          if (t_in_range) begin
            tvalid[tw_addr] <= 1'b1;
          end
          pos  <= pos + 1'b1;
          lane <= lane + 1'b1;
          if (lane == 3'd7) begin
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_issue) begin
            sidx <= sidx + 1'b1;
          end
          if (scan_pv) begin
            if (is_volt) begin
              if (scan_first || (vq[VRAM_W-1:cmfp_pkg::CNT_W] > vmax)) begin
                vmax <= vq[VRAM_W-1:cmfp_pkg::CNT_W];
              end
              if (scan_first || (vq[VRAM_W-1:cmfp_pkg::CNT_W] < vmin)) begin
                vmin <= vq[VRAM_W-1:cmfp_pkg::CNT_W];
              end
            end else begin
              if (scan_first || ($signed(tq) > tmax)) begin
                tmax <= $signed(tq);
              end
              if (scan_first || ($signed(tq) < tmin)) begin
                tmin <= $signed(tq);
              end
            end
          end
          if (!scan_issue && !scan_pv) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data.accepted           <= accepted;
            out_data.over_count         <= over_cnt;
            out_data.max_voltage        <= vmax;
            out_data.min_voltage        <= vmin;
            out_data.max_temp           <= tmax;
            out_data.min_temp           <= tmin;
            out_data.voltage_link_error <= link_err;
            out_valid                   <= 1'b1;
            state                       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/cmfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cmfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cmfp_checker.sv -----
// Port-level checker of the cell monitor frame parser, bound to the top level.
// Depends on cmfp_pkg and cell_monitor_frame_parser_assert.svh.
`include "cell_monitor_frame_parser_assert.svh"

module cmfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input cmfp_pkg::out_t out_data
);

  // a stalled result holds
  `CMFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a result for a poll or rejected frame reports no over-voltage cells
  `CMFP_ASSERT_NOW(a_over_needs_accept, out_valid && !out_data.accepted, out_data.over_count == 3'd0)

  // stored extremes stay ordered
  `CMFP_ASSERT_NOW(a_extremes_order, out_valid, (out_data.max_voltage >= out_data.min_voltage) && (out_data.max_temp >= out_data.min_temp))

  // reset empties the output register
  `CMFP_ASSERT_ALWAYS(a_reset_clears, rst, !out_valid)

endmodule

bind cell_monitor_frame_parser cmfp_checker u_cmfp_checker (.*);
